@@ design/ttcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_pkg: shared types and constants of the chime sequencer
// Widths, codes and the status struct used by the serial arithmetic units
// and the top level.
// ----------------------------------------------------------------------------
package ttcs_pkg;

    localparam int unsigned TIMER_CLOCK_HZ = 1000000;

    // field widths
    localparam int MODE_W    = 2;
    localparam int FREQ_W    = 16;
    localparam int CNT_W     = 8;
    localparam int DUR_W     = 16;
    localparam int VOL_W     = 7;
    localparam int PWM_W     = 16;
    localparam int ELAPSED_W = 18;
    localparam int K_W       = 7;
    localparam int CFG_IDX_W = 2;

    // serial arithmetic sizing
    localparam int CLK_W     = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int MUL_A_W   = 10;              // period / 100 never exceeds 655
    localparam int MUL_B_W   = 14;              // volume * factor stays below 16384
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_W     = (CLK_W > PROD_W) ? CLK_W : PROD_W;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    typedef logic [DIV_W-1:0]     t_quot;
    typedef logic [DVS_W-1:0]     t_divisor;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [MUL_A_W-1:0]   t_mul_a;
    typedef logic [MUL_B_W-1:0]   t_mul_b;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;
    typedef logic [MUL_CNT_W-1:0] t_mul_cnt;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [FREQ_W-1:0]    t_freq;
    typedef logic [VOL_W-1:0]     t_vol;
    typedef logic [K_W-1:0]       t_k;
    typedef logic [PWM_W-1:0]     t_pwm;

    localparam t_freq    FREQ_MIN    = 16'd16;
    localparam t_freq    FREQ_TONE2  = 16'd900;
    localparam t_freq    FREQ_TONE3  = 16'd800;
    localparam t_divisor SCALE_DIV   = 16'd100;
    localparam t_elapsed ELAPSED_MAX = '1;
    localparam t_pwm     PWM_MAX     = '1;

    // balance factors in hundredths
    localparam t_k K_UNITY    = 7'd100;
    localparam t_k K_HIGH_900 = 7'd125;
    localparam t_k K_HIGH_800 = 7'd120;
    localparam t_k K_MID_900  = 7'd90;
    localparam t_k K_MID_800  = 7'd80;
    localparam t_k K_LOW_900  = 7'd76;
    localparam t_k K_LOW_800  = 7'd80;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOL_LOW  = 2'd0,
        CFG_VOL_MID  = 2'd1,
        CFG_VOL_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_PER,
        S_DIV_SCL,
        S_MUL,
        S_DIV_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

@@ design/ttcs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_in_if: input channel of the chime sequencer
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface ttcs_in_if;
    logic                          valid;
    logic                          ready;
    logic [ttcs_pkg::MODE_W-1:0]   mode;
    logic [ttcs_pkg::FREQ_W-1:0]   tone_frequency;
    logic [ttcs_pkg::CNT_W-1:0]    tone_count;
    logic [ttcs_pkg::DUR_W-1:0]    tone_duration;
    logic [ttcs_pkg::VOL_W-1:0]    volume_level;

    modport source (output valid, mode, tone_frequency, tone_count, tone_duration,
                    volume_level, input ready);
    modport sink   (input valid, mode, tone_frequency, tone_count, tone_duration,
                    volume_level, output ready);
endinterface

@@ design/ttcs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_out_if: result channel of the chime sequencer
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ttcs_out_if;
    logic                        valid;
    logic                        ready;
    logic                        tone_on;
    logic [ttcs_pkg::PWM_W-1:0]  pwm_period;
    logic [ttcs_pkg::PWM_W-1:0]  pwm_compare;
    logic                        chime_done;

    modport source (output valid, tone_on, pwm_period, pwm_compare, chime_done,
                    input ready);
    modport sink   (input valid, tone_on, pwm_period, pwm_compare, chime_done,
                    output ready);
endinterface

@@ design/ttcs_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ttcs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ttcs_pkg::CFG_IDX_W-1:0] index;
    logic [ttcs_pkg::VOL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/ttcs_serial_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_serial_div: bit-serial restoring divider
// One quotient bit per cycle until all DIV_W bits are formed; done pulses once.
// ----------------------------------------------------------------------------
module ttcs_serial_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ttcs_pkg::t_quot       i_dividend,
    input  ttcs_pkg::t_divisor    i_divisor,
    output ttcs_pkg::t_quot       o_quotient,
    output ttcs_pkg::t_unit_stat  o_stat
);

    logic                  r_busy;
    logic                  r_done;
    ttcs_pkg::t_div_cnt    r_cnt;
    ttcs_pkg::t_divisor    r_rem;
    ttcs_pkg::t_divisor    r_dvs;
    ttcs_pkg::t_quot       r_dq;

    logic [ttcs_pkg::DVS_W:0] w_sh;
    logic [ttcs_pkg::DVS_W:0] w_diff;
    logic                     w_ge;

    // shift next dividend bit into the partial remainder and trial-subtract
    assign w_sh   = {r_rem, r_dq[ttcs_pkg::DIV_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ttcs_pkg::t_div_cnt'(ttcs_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_ge ? w_diff[ttcs_pkg::DVS_W-1:0] : w_sh[ttcs_pkg::DVS_W-1:0];
            r_dq  <= {r_dq[ttcs_pkg::DIV_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dq  <= i_dividend;
        end
    end

    assign o_quotient  = r_dq;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ design/ttcs_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_serial_mul: shift-add multiplier
// Consumes one multiplier bit per cycle until all MUL_B_W bits are used.
// ----------------------------------------------------------------------------
module ttcs_serial_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ttcs_pkg::t_mul_a      i_mcand,
    input  ttcs_pkg::t_mul_b      i_mplier,
    output ttcs_pkg::t_prod       o_product,
    output ttcs_pkg::t_unit_stat  o_stat
);

    logic                  r_busy;
    logic                  r_done;
    ttcs_pkg::t_mul_cnt    r_cnt;
    ttcs_pkg::t_prod       r_acc;
    ttcs_pkg::t_prod       r_mcand;
    ttcs_pkg::t_mul_b      r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ttcs_pkg::t_mul_cnt'(ttcs_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[ttcs_pkg::PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[ttcs_pkg::MUL_B_W-1:1]};
        end else if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= ttcs_pkg::t_prod'(i_mcand);
            r_mplier <= i_mplier;
        end
    end

    assign o_product   = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ design/three_tone_chime_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tone_chime_sequencer: buzzer chime sequencer
// Plays up to three tones (start frequency, 900 Hz, 800 Hz) and produces
// the PWM reload and compare values for each, one result word per command.
// ----------------------------------------------------------------------------
// Each command word (tick, start or stop) yields exactly one result word:
// tone_on, pwm_period, pwm_compare and chime_done. Tick, stop and unknown
// commands that do not change the tone go from the idle step to the emit
// step, which writes the output register; then the next one can be taken.
// A start command, or a tick that moves to the next tone, recomputes the PWM
// values: the shared bit-serial divider runs three times (clock/f,
// period/100, product/100) and the shift-add multiplier runs once, through
// the steps S_LOAD, S_DIV_PER, S_DIV_SCL, S_MUL and S_DIV_CMP before S_EMIT;
// the next command is taken once that word has been emitted. A result that
// waits on the output channel holds the sequencer in its emit step.
// One command is processed at a time; a finished result sits in the output
// register while the next command is accepted. Configuration writes set the
// three volume codes that pick the balance factors and are always accepted.
// ----------------------------------------------------------------------------
module three_tone_chime_sequencer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ttcs_in_if.sink    i_in,
    ttcs_out_if.source o_out,
    ttcs_cfg_if.sink   i_cfg
);

    // ------------------------------------------------------------------
    // balance factor select: high code wins, then mid, then low
    // ------------------------------------------------------------------
    function automatic ttcs_pkg::t_k balance_factor(
        input ttcs_pkg::t_freq f,
        input ttcs_pkg::t_vol  vol,
        input ttcs_pkg::t_vol  code_low,
        input ttcs_pkg::t_vol  code_mid,
        input ttcs_pkg::t_vol  code_high
    );
        ttcs_pkg::t_k k;
        k = ttcs_pkg::K_UNITY;
        if (vol == code_high) begin
            if (f == ttcs_pkg::FREQ_TONE2)      k = ttcs_pkg::K_HIGH_900;
            else if (f == ttcs_pkg::FREQ_TONE3) k = ttcs_pkg::K_HIGH_800;
        end else if (vol == code_mid) begin
            if (f == ttcs_pkg::FREQ_TONE2)      k = ttcs_pkg::K_MID_900;
            else if (f == ttcs_pkg::FREQ_TONE3) k = ttcs_pkg::K_MID_800;
        end else if (vol == code_low) begin
            if (f == ttcs_pkg::FREQ_TONE2)      k = ttcs_pkg::K_LOW_900;
            else if (f == ttcs_pkg::FREQ_TONE3) k = ttcs_pkg::K_LOW_800;
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    ttcs_pkg::t_state    r_state,   n_state;
    ttcs_pkg::t_elapsed  r_elapsed, n_elapsed;
    logic                r_running, n_running;
    logic [ttcs_pkg::CNT_W-1:0] r_wanted, n_wanted;
    logic [ttcs_pkg::DUR_W-1:0] r_length, n_length;
    ttcs_pkg::t_vol      r_vol,     n_vol;
    ttcs_pkg::t_pwm      r_period,  n_period;
    ttcs_pkg::t_pwm      r_compare, n_compare;
    ttcs_pkg::t_freq     r_freq,    n_freq;
    ttcs_pkg::t_mul_b    r_vk,      n_vk;
    logic                r_done,    n_done;

    ttcs_pkg::t_vol      r_code_low, r_code_mid, r_code_high;

    logic                r_out_valid, n_out_valid;
    logic                r_o_tone_on;
    ttcs_pkg::t_pwm      r_o_period;
    ttcs_pkg::t_pwm      r_o_compare;
    logic                r_o_done;

    // ------------------------------------------------------------------
    // arithmetic units
    // ------------------------------------------------------------------
    logic                  w_div_start;
    ttcs_pkg::t_quot       w_div_dividend;
    ttcs_pkg::t_divisor    w_div_divisor;
    ttcs_pkg::t_quot       w_quot;
    ttcs_pkg::t_unit_stat  w_div_stat;

    logic                  w_mul_start;
    ttcs_pkg::t_prod       w_product;
    ttcs_pkg::t_unit_stat  w_mul_stat;

    ttcs_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_quotient (w_quot),
        .o_stat     (w_div_stat)
    );

    ttcs_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_quot[ttcs_pkg::MUL_A_W-1:0]),
        .i_mplier  (r_vk),
        .o_product (w_product),
        .o_stat    (w_mul_stat)
    );

    // ------------------------------------------------------------------
    // tick bookkeeping: saturating increment and tone boundaries
    // ------------------------------------------------------------------
    ttcs_pkg::t_elapsed w_inc;
    ttcs_pkg::t_elapsed w_len1, w_len2, w_len3;
    logic               w_hit1, w_hit2, w_hit3, w_stop;
    logic               w_in_acc;
    logic               w_emit;
    ttcs_pkg::t_quot    w_q_m1;
    ttcs_pkg::t_pwm     w_per;
    ttcs_pkg::t_pwm     w_cmp;
    ttcs_pkg::t_freq    w_freq_in;

    assign w_inc  = r_elapsed + ttcs_pkg::t_elapsed'(r_elapsed != ttcs_pkg::ELAPSED_MAX);
    assign w_len1 = ttcs_pkg::t_elapsed'(r_length);
    assign w_len2 = ttcs_pkg::t_elapsed'({r_length, 1'b0});
    assign w_len3 = w_len1 + w_len2;
    assign w_hit1 = (w_inc == w_len1);
    assign w_hit2 = (w_inc == w_len2);
    assign w_hit3 = (w_inc == w_len3);
    assign w_stop = (w_hit1 && (r_wanted == 8'd1)) ||
                    (w_hit2 && (r_wanted == 8'd2)) ||
                    (w_hit3 && (r_wanted == 8'd3));

    // clamp the start frequency from below
    assign w_freq_in = (i_in.tone_frequency < ttcs_pkg::FREQ_MIN) ?
                       ttcs_pkg::FREQ_MIN : i_in.tone_frequency;

    // period = clock/f - 1, saturated; compare = product/100, saturated
    assign w_q_m1 = w_quot - 1'b1;
    assign w_per  = (w_quot == '0) ? '0 :
                    (w_q_m1 > ttcs_pkg::t_quot'(ttcs_pkg::PWM_MAX)) ? ttcs_pkg::PWM_MAX :
                    w_q_m1[ttcs_pkg::PWM_W-1:0];
    assign w_cmp  = (w_quot > ttcs_pkg::t_quot'(ttcs_pkg::PWM_MAX)) ? ttcs_pkg::PWM_MAX :
                    w_quot[ttcs_pkg::PWM_W-1:0];

    assign i_in.ready = (r_state == ttcs_pkg::S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // sequencer: next state and unit control
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_running   = r_running;
        n_wanted    = r_wanted;
        n_length    = r_length;
        n_vol       = r_vol;
        n_period    = r_period;
        n_compare   = r_compare;
        n_freq      = r_freq;
        n_vk        = r_vk;
        n_done      = r_done;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        w_emit      = 1'b0;
        w_div_dividend = ttcs_pkg::t_quot'(ttcs_pkg::TIMER_CLOCK_HZ);
        w_div_divisor  = r_freq;

        case (r_state)
            ttcs_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_done  = 1'b0;
                    n_state = ttcs_pkg::S_EMIT;
                    case (ttcs_pkg::t_mode'(i_in.mode))
                        ttcs_pkg::MODE_START: begin
                            // restart with the new settings, first tone
                            n_elapsed = '0;
                            n_running = 1'b1;
                            n_wanted  = i_in.tone_count;
                            n_length  = i_in.tone_duration;
                            n_vol     = i_in.volume_level;
                            n_freq    = w_freq_in;
                            n_state   = ttcs_pkg::S_LOAD;
                        end
                        ttcs_pkg::MODE_STOP: begin
                            n_done    = r_running;
                            n_elapsed = '0;
                            n_running = 1'b0;
                            n_wanted  = '0;
                            n_length  = '0;
                            n_vol     = '0;
                            n_period  = '0;
                            n_compare = '0;
                        end
                        ttcs_pkg::MODE_TICK: begin
                            if (r_running) begin
                                n_elapsed = w_inc;
                                if (w_stop) begin
                                    // sequence end: drop everything
                                    n_done    = 1'b1;
                                    n_elapsed = '0;
                                    n_running = 1'b0;
                                    n_wanted  = '0;
                                    n_length  = '0;
                                    n_vol     = '0;
                                    n_period  = '0;
                                    n_compare = '0;
                                end else if (w_hit1) begin
                                    n_freq  = ttcs_pkg::FREQ_TONE2;
                                    n_state = ttcs_pkg::S_LOAD;
                                end else if (w_hit2) begin
                                    n_freq  = ttcs_pkg::FREQ_TONE3;
                                    n_state = ttcs_pkg::S_LOAD;
                                end
                            end
                        end
                        default: begin
                            n_state = ttcs_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            ttcs_pkg::S_LOAD: begin
                // volume times balance factor, and start clock / f
                n_vk = ttcs_pkg::t_mul_b'(r_vol) *
                       ttcs_pkg::t_mul_b'(balance_factor(r_freq, r_vol, r_code_low,
                                                         r_code_mid, r_code_high));
                w_div_start = 1'b1;
                n_state     = ttcs_pkg::S_DIV_PER;
            end
            ttcs_pkg::S_DIV_PER: begin
                w_div_dividend = ttcs_pkg::t_quot'(w_per);
                w_div_divisor  = ttcs_pkg::SCALE_DIV;
                if (w_div_stat.done) begin
                    n_period    = w_per;
                    w_div_start = 1'b1;
                    n_state     = ttcs_pkg::S_DIV_SCL;
                end
            end
            ttcs_pkg::S_DIV_SCL: begin
                if (w_div_stat.done) begin
                    w_mul_start = 1'b1;
                    n_state     = ttcs_pkg::S_MUL;
                end
            end
            ttcs_pkg::S_MUL: begin
                w_div_dividend = ttcs_pkg::t_quot'(w_product);
                w_div_divisor  = ttcs_pkg::SCALE_DIV;
                if (w_mul_stat.done) begin
                    w_div_start = 1'b1;
                    n_state     = ttcs_pkg::S_DIV_CMP;
                end
            end
            ttcs_pkg::S_DIV_CMP: begin
                if (w_div_stat.done) begin
                    n_compare = w_cmp;
                    n_state   = ttcs_pkg::S_EMIT;
                end
            end
            ttcs_pkg::S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    w_emit  = 1'b1;
                    n_state = ttcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttcs_pkg::S_IDLE;
            end
        endcase

        n_out_valid = w_emit ? 1'b1 : (r_out_valid && !o_out.ready);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttcs_pkg::S_IDLE;
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_wanted    <= '0;
            r_length    <= '0;
            r_vol       <= '0;
            r_period    <= '0;
            r_compare   <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_wanted    <= n_wanted;
            r_length    <= n_length;
            r_vol       <= n_vol;
            r_period    <= n_period;
            r_compare   <= n_compare;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers, valid only while a tone is loading
    always_ff @(posedge i_clk) begin
        r_freq <= n_freq;
        r_vk   <= n_vk;
    end

    // volume codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_low  <= 7'd1;
            r_code_mid  <= 7'd2;
            r_code_high <= 7'd3;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (ttcs_pkg::t_cfg_idx'(i_cfg.index))
                ttcs_pkg::CFG_VOL_LOW:  r_code_low  <= i_cfg.data;
                ttcs_pkg::CFG_VOL_MID:  r_code_mid  <= i_cfg.data;
                ttcs_pkg::CFG_VOL_HIGH: r_code_high <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_tone_on <= r_running;
            r_o_period  <= r_period;
            r_o_compare <= r_compare;
            r_o_done    <= r_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tone_on     = r_o_tone_on;
    assign o_out.pwm_period  = r_o_period;
    assign o_out.pwm_compare = r_o_compare;
    assign o_out.chime_done  = r_o_done;

`ifndef NO_ASSERTIONS
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ttcs_pkg::S_DIV_PER ||
                             r_state == ttcs_pkg::S_DIV_SCL ||
                             r_state == ttcs_pkg::S_DIV_CMP))
        else $error("divider finished outside a divide state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_state == ttcs_pkg::S_MUL))
        else $error("multiplier finished outside the multiply state");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_stat.busy && w_mul_stat.busy))
        else $error("divider and multiplier busy together");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_period == '0 && r_compare == '0 && r_elapsed == '0))
        else $error("stopped chime left tone state behind");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && r_state == ttcs_pkg::S_IDLE))
        else $error("emitted word not held in output register");
`endif

endmodule

@@ tb/three_tone_chime_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tone_chime_sequencer_test: self-checking bench for the chime sequencer
// Drives tick, start, stop and spare command words with random idle gaps on
// both channels, predicts every result word in step with the block, and
// checks tone state, PWM reload/compare values and the end flag field by field.
// ----------------------------------------------------------------------------
module three_tone_chime_sequencer_test;

    typedef logic [ttcs_pkg::MODE_W-1:0] t_op;
    typedef logic [ttcs_pkg::CNT_W-1:0]  t_cnt;
    typedef logic [ttcs_pkg::DUR_W-1:0]  t_dur;

    // The fourth mode encoding has no meaning; the block must ignore it.
    localparam t_op MODE_SPARE = 2'd3;
    // Longest word comes from a start or tone change; leave margin.
    localparam int SETTLE_CYCLES = 120;
    localparam int GAP_MAX       = 18;
    localparam int MISMATCH_SHOW = 10;

    typedef struct packed {
        logic           tone_on;
        ttcs_pkg::t_pwm period;
        ttcs_pkg::t_pwm compare;
        logic           chime_done;
    } t_chime_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttcs_in_if  cmd_if ();
    ttcs_out_if pwm_if ();
    ttcs_cfg_if cfg_if ();

    three_tone_chime_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (pwm_if),
        .i_cfg   (cfg_if)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted block state: volume codes plus the running chime.
    // ------------------------------------------------------------------
    ttcs_pkg::t_vol     code_low  = 7'd1;
    ttcs_pkg::t_vol     code_mid  = 7'd2;
    ttcs_pkg::t_vol     code_high = 7'd3;
    ttcs_pkg::t_elapsed elapsed;
    logic               running;
    t_cnt               tones_wanted;
    t_dur               tone_len;
    ttcs_pkg::t_vol     vol_held;
    ttcs_pkg::t_pwm     period_now;
    ttcs_pkg::t_pwm     compare_now;

    t_chime_word chime_words_due[$];   // results still owed by the block
    int          mismatch_total;
    int          results_seen;
    int          live_words;           // words that started, advanced or stopped a chime
    bit          steady_flow;          // set: neither side idles

    function automatic int pick_gap();
        if (steady_flow)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void clear_chime_state();
        elapsed      = '0;
        running      = 1'b0;
        tones_wanted = '0;
        tone_len     = '0;
        vol_held     = '0;
        period_now   = '0;
        compare_now  = '0;
    endfunction

    // Reload = clock/f - 1; compare = (reload/100) * volume * factor / 100,
    // where the factor depends on which volume code matches (high first).
    function automatic void set_tone_pwm(ttcs_pkg::t_freq freq, ttcs_pkg::t_vol vol);
        ttcs_pkg::t_freq   f;
        int unsigned       reload;
        ttcs_pkg::t_k      factor;
        longint unsigned   base;
        longint unsigned   duty;
        f      = (freq < ttcs_pkg::FREQ_MIN) ? ttcs_pkg::FREQ_MIN : freq;
        reload = ttcs_pkg::TIMER_CLOCK_HZ / 32'(f);
        reload = (reload == 0) ? 0 : reload - 1;
        if (reload > 32'(ttcs_pkg::PWM_MAX))
            reload = 32'(ttcs_pkg::PWM_MAX);
        factor = ttcs_pkg::K_UNITY;
        if (vol == code_high) begin
            if (f == ttcs_pkg::FREQ_TONE2)      factor = ttcs_pkg::K_HIGH_900;
            else if (f == ttcs_pkg::FREQ_TONE3) factor = ttcs_pkg::K_HIGH_800;
        end else if (vol == code_mid) begin
            if (f == ttcs_pkg::FREQ_TONE2)      factor = ttcs_pkg::K_MID_900;
            else if (f == ttcs_pkg::FREQ_TONE3) factor = ttcs_pkg::K_MID_800;
        end else if (vol == code_low) begin
            if (f == ttcs_pkg::FREQ_TONE2)      factor = ttcs_pkg::K_LOW_900;
            else if (f == ttcs_pkg::FREQ_TONE3) factor = ttcs_pkg::K_LOW_800;
        end
        base = 64'(reload / 32'(ttcs_pkg::SCALE_DIV));
        duty = (base * 64'(vol) * 64'(factor)) / 64'(ttcs_pkg::SCALE_DIV);
        if (duty > 64'(ttcs_pkg::PWM_MAX))
            duty = 64'(ttcs_pkg::PWM_MAX);
        period_now  = ttcs_pkg::t_pwm'(reload);
        compare_now = ttcs_pkg::t_pwm'(duty);
    endfunction

    // Advance the predicted chime by one accepted command word.
    function automatic t_chime_word advance_chime(t_op op, ttcs_pkg::t_freq freq,
                                                  t_cnt cnt, t_dur dur,
                                                  ttcs_pkg::t_vol vol);
        t_chime_word res;
        logic        finished;
        int unsigned span;
        finished       = 1'b0;
        res.chime_done = 1'b0;
        if (op == ttcs_pkg::MODE_START) begin
            elapsed      = '0;
            running      = 1'b1;
            tones_wanted = cnt;
            tone_len     = dur;
            vol_held     = vol;
            set_tone_pwm(freq, vol);
            live_words++;
        end else if (op == ttcs_pkg::MODE_STOP) begin
            if (running)
                live_words++;
            res.chime_done = running;
            clear_chime_state();
        end else if (op == ttcs_pkg::MODE_TICK && running) begin
            live_words++;
            if (elapsed != ttcs_pkg::ELAPSED_MAX)
                elapsed++;
            span = 32'(tone_len);
            if (32'(elapsed) == span) begin
                set_tone_pwm(ttcs_pkg::FREQ_TONE2, vol_held);
                if (tones_wanted == 1)
                    finished = 1'b1;
            end
            if (32'(elapsed) == 2 * span) begin
                set_tone_pwm(ttcs_pkg::FREQ_TONE3, vol_held);
                if (tones_wanted == 2)
                    finished = 1'b1;
            end
            if (32'(elapsed) == 3 * span && tones_wanted == 3)
                finished = 1'b1;
            if (finished) begin
                clear_chime_state();
                res.chime_done = 1'b1;
            end
        end
        res.tone_on = running;
        res.period  = period_now;
        res.compare = compare_now;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command channel. Valid stays high after a handshake; it is dropped
    // only when the next word waits out a gap or the bench settles, so
    // valid never gets two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_word(t_op op, ttcs_pkg::t_freq freq, t_cnt cnt, t_dur dur,
                             ttcs_pkg::t_vol vol);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.mode           <= op;
        cmd_if.tone_frequency <= freq;
        cmd_if.tone_count     <= cnt;
        cmd_if.tone_duration  <= dur;
        cmd_if.volume_level   <= vol;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        chime_words_due.push_back(advance_chime(op, freq, cnt, dur, vol));
    endtask

    // Word with random payload that the block must ignore.
    task automatic send_noise(t_op op);
        send_word(op, ttcs_pkg::t_freq'($urandom), t_cnt'($urandom), t_dur'($urandom),
                  ttcs_pkg::t_vol'($urandom));
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet.
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (chime_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three volume codes back to back; valid holds across them.
    task automatic load_volume_codes(ttcs_pkg::t_vol lo, ttcs_pkg::t_vol mid,
                                     ttcs_pkg::t_vol hi);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= ttcs_pkg::CFG_VOL_LOW;
        cfg_if.data  <= lo;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        code_low = lo;
        cfg_if.index <= ttcs_pkg::CFG_VOL_MID;
        cfg_if.data  <= mid;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        code_mid = mid;
        cfg_if.index <= ttcs_pkg::CFG_VOL_HIGH;
        cfg_if.data  <= hi;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        code_high = hi;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking: random stalls on ready, compare against the oldest
    // prediction.
    // ------------------------------------------------------------------
    task automatic flag_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatch_total < MISMATCH_SHOW)
                $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
            mismatch_total++;
        end
    endtask

    initial begin : result_checker
        t_chime_word got;
        t_chime_word want;
        int          stall;
        pwm_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        stall = pick_gap();
        forever begin
            if (stall > 0) begin
                pwm_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pwm_if.ready <= 1'b1;
            do @(posedge i_clk); while (pwm_if.valid !== 1'b1);
            got.tone_on    = pwm_if.tone_on;
            got.period     = pwm_if.pwm_period;
            got.compare    = pwm_if.pwm_compare;
            got.chime_done = pwm_if.chime_done;
            if (chime_words_due.size() == 0) begin
                if (mismatch_total < MISMATCH_SHOW)
                    $display("result %0d: word arrived with nothing pending", results_seen);
                mismatch_total++;
            end else begin
                want = chime_words_due.pop_front();
                flag_field("tone_on", want.tone_on, got.tone_on);
                flag_field("pwm_period", want.period, got.period);
                flag_field("pwm_compare", want.compare, got.compare);
                flag_field("chime_done", want.chime_done, got.chime_done);
            end
            results_seen++;
            stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle block: a tick changes nothing, a stop reports no end, the spare
    // mode is ignored.
    task automatic test_idle_commands();
        send_word(ttcs_pkg::MODE_TICK, 16'd900, 8'd1, 16'd1, 7'd3);
        send_word(ttcs_pkg::MODE_STOP, 16'd0, 8'd0, 16'd0, 7'd0);
        send_word(MODE_SPARE, 16'hFFFF, 8'hFF, 16'hFFFF, 7'h7F);
    endtask

    // Reload and compare arithmetic at the field extremes; each start after the
    // first restarts the chime already running. Codes are at their reset values.
    task automatic test_pwm_arithmetic();
        // frequency below the floor, volume over 100: compare saturates
        send_word(ttcs_pkg::MODE_START, 16'd0, 8'd3, 16'd10, 7'd127);
        send_word(ttcs_pkg::MODE_START, 16'd15, 8'd3, 16'd10, 7'd0);
        send_word(ttcs_pkg::MODE_START, 16'hFFFF, 8'd3, 16'd10, 7'd100);
        // first tone already at the factor frequencies, each code class
        send_word(ttcs_pkg::MODE_START, ttcs_pkg::FREQ_TONE2, 8'd3, 16'd10, 7'd3);
        send_word(ttcs_pkg::MODE_START, ttcs_pkg::FREQ_TONE3, 8'd3, 16'd10, 7'd2);
        send_word(ttcs_pkg::MODE_START, ttcs_pkg::FREQ_TONE2, 8'd3, 16'd10, 7'd1);
    endtask

    // Tone changes and the end of the sequence for each kind of count.
    task automatic test_tone_sequencing();
        // one tone of two ticks: ends on the second tick
        send_word(ttcs_pkg::MODE_START, 16'd1000, 8'd1, 16'd2, 7'd3);
        send_word(ttcs_pkg::MODE_TICK, 16'd0, 8'd0, 16'd0, 7'd0);
        send_word(ttcs_pkg::MODE_TICK, 16'd0, 8'd0, 16'd0, 7'd0);
        // three one-tick tones: 900 Hz, 800 Hz, then end
        send_word(ttcs_pkg::MODE_START, 16'd2000, 8'd3, 16'd1, 7'd1);
        repeat (3) send_word(ttcs_pkg::MODE_TICK, 16'd0, 8'd0, 16'd0, 7'd0);
        // count zero: the third tone holds until the stop word
        send_word(ttcs_pkg::MODE_START, 16'd440, 8'd0, 16'd1, 7'd3);
        repeat (4) send_word(ttcs_pkg::MODE_TICK, 16'd0, 8'd0, 16'd0, 7'd0);
        send_word(ttcs_pkg::MODE_STOP, 16'd0, 8'd0, 16'd0, 7'd0);
        // zero length with count above three: first tone holds
        send_word(ttcs_pkg::MODE_START, 16'd3000, 8'd5, 16'd0, 7'd2);
        repeat (2) send_word(ttcs_pkg::MODE_TICK, 16'd0, 8'd0, 16'd0, 7'd0);
        send_word(ttcs_pkg::MODE_STOP, 16'd0, 8'd0, 16'd0, 7'd0);
    endtask

    // One well-formed chime with random content: start, about enough ticks
    // to finish, a spare word now and then, and sometimes a stop.
    task automatic play_one_chime();
        ttcs_pkg::t_freq freq;
        t_cnt            cnt;
        t_dur            dur;
        ttcs_pkg::t_vol  vol;
        int              ticks;
        case ($urandom_range(0, 7))
            0: freq = ttcs_pkg::FREQ_TONE2;
            1: freq = ttcs_pkg::FREQ_TONE3;
            2: freq = ttcs_pkg::t_freq'($urandom_range(0, 15));
            3: freq = 16'hFFFF;
            4: freq = ttcs_pkg::FREQ_MIN;
            5: freq = ttcs_pkg::t_freq'($urandom_range(16, 2000));
            default: freq = ttcs_pkg::t_freq'($urandom_range(0, 65535));
        endcase
        cnt = ($urandom_range(0, 9) == 0) ? t_cnt'($urandom_range(4, 255)) :
                                            t_cnt'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: dur = t_dur'($urandom_range(6, 30));
            1: dur = t_dur'($urandom_range(0, 65535));
            default: dur = t_dur'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 5))
            0: vol = code_low;
            1: vol = code_mid;
            2: vol = code_high;
            3: vol = 7'd100;
            default: vol = ttcs_pkg::t_vol'($urandom_range(0, 127));
        endcase
        send_word(ttcs_pkg::MODE_START, freq, cnt, dur, vol);
        if (dur >= 1 && dur <= 30)
            ticks = $urandom_range(3 * dur - 1, 3 * dur + 2);
        else
            ticks = $urandom_range(1, 8);
        // tick words carry random payload that the block must ignore
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_noise(MODE_SPARE);
            else
                send_noise(ttcs_pkg::MODE_TICK);
        end
        if ($urandom_range(0, 4) < 2)
            send_noise(ttcs_pkg::MODE_STOP);
    endtask

    // Random chimes under several volume code settings, written while idle.
    task automatic test_random_chimes();
        ttcs_pkg::t_vol codes[5][3];
        int             first;
        codes = '{'{7'd0, 7'd0, 7'd0}, '{7'd100, 7'd100, 7'd100},
                  '{7'd50, 7'd50, 7'd7}, '{7'd100, 7'd0, 7'd64},
                  '{7'd0, 7'd0, 7'd0}};
        codes[4] = '{ttcs_pkg::t_vol'($urandom_range(0, 100)),
                     ttcs_pkg::t_vol'($urandom_range(0, 100)),
                     ttcs_pkg::t_vol'($urandom_range(0, 100))};
        for (int p = 0; p < 5; p++) begin
            settle();
            load_volume_codes(codes[p][0], codes[p][1], codes[p][2]);
            first = live_words;
            while (live_words - first < 150) begin
                // flip into and out of gap-free stretches
                if ($urandom_range(0, 99) < 4)
                    steady_flow = ~steady_flow;
                if ($urandom_range(0, 99) < 85)
                    play_one_chime();
                else
                    send_noise(t_op'($urandom_range(0, 3)));
            end
            steady_flow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_chime_state();
        i_rst_n               <= 1'b0;
        cmd_if.valid          <= 1'b0;
        cmd_if.mode           <= ttcs_pkg::MODE_TICK;
        cmd_if.tone_frequency <= '0;
        cmd_if.tone_count     <= '0;
        cmd_if.tone_duration  <= '0;
        cmd_if.volume_level   <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= ttcs_pkg::CFG_VOL_LOW;
        cfg_if.data           <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_pwm_arithmetic();
        test_tone_sequencing();
        test_random_chimes();
        settle();

        if (mismatch_total == 0)
            $display("three_tone_chime_sequencer_test: clean");
        else
            $display("three_tone_chime_sequencer_test: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("three_tone_chime_sequencer_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ttcs_pkg.sv
design/ttcs_in_if.sv
design/ttcs_out_if.sv
design/ttcs_cfg_if.sv
design/ttcs_serial_div.sv
design/ttcs_serial_mul.sv
design/three_tone_chime_sequencer.sv
tb/three_tone_chime_sequencer_test.sv
